>>> rtl/urldec_pkg.sv
// Shared types, character constants and hex helpers for the URL percent decoder.
`timescale 1ns / 1ps

package urldec_pkg;

   typedef enum logic [1:0] {
      HELD_NONE  = 2'd0,
      HELD_PCT   = 2'd1,
      HELD_DIGIT = 2'd2
   } held_type;

   localparam logic [7:0] CHAR_PCT   = 8'h25;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam int unsigned MAX_RESULTS = 3;

   typedef struct packed {
      logic [1:0]                     count;
      logic [MAX_RESULTS-1:0][7:0]    bytes;
      logic                           last;
   } dec_type;

   function automatic logic hex_ok(input logic [7:0] b);
      hex_ok = ((b >= 8'h30) && (b <= 8'h39)) ||
               ((b >= 8'h61) && (b <= 8'h66)) ||
               ((b >= 8'h41) && (b <= 8'h46));
   endfunction

   function automatic logic [3:0] hex_nibble(input logic [7:0] b);
      if (b <= 8'h39) begin
         hex_nibble = b[3:0];
      end else begin
         hex_nibble = b[3:0] + 4'd9;
      end
   endfunction

endpackage

>>> rtl/url_percent_decoder.sv
// An accepted word goes through the input register, then the result register. Throughput: one
// word per cycle while words yield at most one byte and rsp_ready is high; a word with two
// or three bytes holds the result register; the input register takes one more word meanwhile.
// Reset (synchronous, active high) clears all held escape state and pending bytes
// and sets plus-as-space on.
`timescale 1ns / 1ps

module url_percent_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   logic                 plus_ff;
   logic                 stage_valid_ff, stage_valid_in;
   logic [7:0]           stage_byte_ff;
   logic                 stage_last_ff;
   logic                 empty_next;
   logic                 load;
   urldec_pkg::dec_type  dec;
   urldec_pkg::held_type held;
   logic [7:0]           held_digit;

   assign load      = stage_valid_ff && empty_next;
   assign req_ready = !stage_valid_ff || load;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_valid && req_ready) begin
         stage_valid_in = 1'b1;
      end else if (load) begin
         stage_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         plus_ff        <= 1'b1;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (csr_wr_en) begin
            plus_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_byte_ff <= req_in_byte;
         stage_last_ff <= req_in_last;
      end
   end

   urldec_dec u_dec (
      .clock         (clock),
      .reset         (reset),
      .step          (load),
      .plus_as_space (plus_ff),
      .in_byte       (stage_byte_ff),
      .in_last       (stage_last_ff),
      .dec           (dec),
      .held          (held),
      .held_digit    (held_digit)
   );

   urldec_obuf u_obuf (
      .clock        (clock),
      .reset        (reset),
      .load         (load),
      .dec          (dec),
      .empty_next   (empty_next),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

   // The end of a string always produces at least one byte and leaves nothing held.
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (load && stage_last_ff) |=> (rsp_valid && (held == urldec_pkg::HELD_NONE)))
      else $error("last word did not flush");

   // A digit is held only when it is a valid hex character.
   a_digit_hex: assert property (@(posedge clock) disable iff (reset)
      (held == urldec_pkg::HELD_DIGIT) |-> urldec_pkg::hex_ok(held_digit))
      else $error("held digit is not hex");

   // A staged word waits unchanged until it moves into the result register.
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (stage_valid_ff && !load) |=> (stage_valid_ff && $stable(stage_byte_ff)
                                      && $stable(stage_last_ff)))
      else $error("staged word lost");

   // A flagged final byte is never followed by more bytes of the same word.
   a_last_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_out_last && !load) |=> !rsp_valid)
      else $error("bytes after final byte");

endmodule

>>> rtl/urldec_dec.sv
// Escape tracking state and the per-word decode into up to three output bytes.
`timescale 1ns / 1ps

module urldec_dec (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic                 plus_as_space,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   output urldec_pkg::dec_type  dec,
   output urldec_pkg::held_type held,
   output logic [7:0]           held_digit
);

   urldec_pkg::held_type held_ff, held_in;
   logic [7:0]           digit_ff, digit_in;
   logic                 hv;
   logic                 fresh_hold;
   logic [7:0]           fresh_byte;

   assign hv         = urldec_pkg::hex_ok(in_byte);
   assign fresh_hold = (in_byte == urldec_pkg::CHAR_PCT) && !in_last;
   assign fresh_byte = ((in_byte == urldec_pkg::CHAR_PLUS) && plus_as_space) ?
                       urldec_pkg::CHAR_SPACE : in_byte;

   always_comb begin
      held_in   = urldec_pkg::HELD_NONE;
      digit_in  = digit_ff;
      dec.count = 2'd0;
      dec.bytes = '0;
      dec.last  = in_last;
      unique case (held_ff)
         urldec_pkg::HELD_PCT: begin
            if (hv && !in_last) begin
               held_in  = urldec_pkg::HELD_DIGIT;
               digit_in = in_byte;
            end else begin
               dec.bytes[0] = urldec_pkg::CHAR_PCT;
               if (fresh_hold) begin
                  held_in   = urldec_pkg::HELD_PCT;
                  dec.count = 2'd1;
               end else begin
                  dec.bytes[1] = fresh_byte;
                  dec.count    = 2'd2;
               end
            end
         end
         urldec_pkg::HELD_DIGIT: begin
            if (hv) begin
               dec.bytes[0] = {urldec_pkg::hex_nibble(digit_ff),
                               urldec_pkg::hex_nibble(in_byte)};
               dec.count    = 2'd1;
            end else begin
               dec.bytes[0] = urldec_pkg::CHAR_PCT;
               dec.bytes[1] = digit_ff;
               if (fresh_hold) begin
                  held_in   = urldec_pkg::HELD_PCT;
                  dec.count = 2'd2;
               end else begin
                  dec.bytes[2] = fresh_byte;
                  dec.count    = 2'd3;
               end
            end
         end
         default: begin
            if (fresh_hold) begin
               held_in = urldec_pkg::HELD_PCT;
            end else begin
               dec.bytes[0] = fresh_byte;
               dec.count    = 2'd1;
            end
         end
      endcase
      if (in_last) begin
         held_in = urldec_pkg::HELD_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff  <= urldec_pkg::HELD_NONE;
         digit_ff <= 8'h00;
      end else if (step) begin
         held_ff  <= held_in;
         digit_ff <= digit_in;
      end
   end

   assign held       = held_ff;
   assign held_digit = digit_ff;

endmodule

>>> rtl/urldec_obuf.sv
// Result register that holds the decoded bytes of one word and hands them out in order.
`timescale 1ns / 1ps

module urldec_obuf (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  urldec_pkg::dec_type dec,
   output logic                empty_next,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_out_last
);

   logic [1:0]                                num_ff, num_in;
   logic [urldec_pkg::MAX_RESULTS-1:0][7:0]   buf_ff, buf_in;
   logic                                      last_ff, last_in;
   logic                                      pop;

   assign pop        = (num_ff != 2'd0) && rsp_ready;
   assign empty_next = (num_ff == 2'd0) || ((num_ff == 2'd1) && rsp_ready);

   always_comb begin
      num_in  = num_ff;
      buf_in  = buf_ff;
      last_in = last_ff;
      if (load) begin
         num_in  = dec.count;
         buf_in  = dec.bytes;
         last_in = dec.last;
      end else if (pop) begin
         num_in = num_ff - 2'd1;
         buf_in = {8'h00, buf_ff[urldec_pkg::MAX_RESULTS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= 2'd0;
      end else begin
         num_ff <= num_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff  <= buf_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = (num_ff != 2'd0);
   assign rsp_out_byte = buf_ff[0];
   assign rsp_out_last = last_ff && (num_ff == 2'd1);

endmodule

>>> dv/urldec_checker.sv
// Checker for the URL percent decoder: predicts decoded words and compares the result channel.
`timescale 1ns / 1ps

module urldec_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_out_last,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   output int         mismatch_count,
   output int         pending_count
);

   typedef struct {
      logic [7:0] data;
      logic       last;
   } decoded_word_type;

   decoded_word_type     decoded_q[$];
   urldec_pkg::held_type held_state = urldec_pkg::HELD_NONE;
   logic [7:0]           held_char = 8'h00;
   logic                 plus_space = 1'b1;
   int                   errors = 0;

   // Bit 4 flags a hexadecimal digit character, bits 3:0 hold its value.
   function automatic logic [4:0] hex_lookup(input logic [7:0] c);
      logic [7:0] value;
      value = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) begin
         value = c - 8'h30;
         return {1'b1, value[3:0]};
      end
      if (c >= 8'h41 && c <= 8'h46) begin
         value = c - 8'h37;
         return {1'b1, value[3:0]};
      end
      if (c >= 8'h61 && c <= 8'h66) begin
         value = c - 8'h57;
         return {1'b1, value[3:0]};
      end
      return 5'd0;
   endfunction

   task automatic decode_word(input logic [7:0] b, input logic last);
      logic [7:0]           produced [0:2];
      int                   n;
      logic                 examine;
      logic [4:0]           cur;
      logic [4:0]           prev;
      urldec_pkg::held_type prior;
      decoded_word_type     w;
      n = 0;
      examine = 1'b0;
      cur = hex_lookup(b);
      prev = hex_lookup(held_char);
      prior = held_state;
      held_state = urldec_pkg::HELD_NONE;
      case (prior)
         urldec_pkg::HELD_PCT: begin
            if (cur[4] && !last) begin
               held_state = urldec_pkg::HELD_DIGIT;
               held_char = b;
            end else begin
               produced[n] = urldec_pkg::CHAR_PCT;
               n = n + 1;
               examine = 1'b1;
            end
         end
         urldec_pkg::HELD_DIGIT: begin
            if (cur[4] && prev[4]) begin
               produced[n] = {prev[3:0], cur[3:0]};
               n = n + 1;
            end else begin
               produced[n] = urldec_pkg::CHAR_PCT;
               produced[n + 1] = held_char;
               n = n + 2;
               examine = 1'b1;
            end
         end
         default: begin
            examine = 1'b1;
         end
      endcase
      // A byte that breaks an escape is looked at again as a fresh byte.
      if (examine) begin
         if (b == urldec_pkg::CHAR_PCT && !last) begin
            held_state = urldec_pkg::HELD_PCT;
         end else begin
            produced[n] = (b == urldec_pkg::CHAR_PLUS && plus_space) ?
                          urldec_pkg::CHAR_SPACE : b;
            n = n + 1;
         end
      end
      if (last) begin
         held_state = urldec_pkg::HELD_NONE;
      end
      for (int i = 0; i < n; i++) begin
         w.data = produced[i];
         w.last = last && (i == n - 1);
         decoded_q.push_back(w);
      end
   endtask

   always @(posedge clock) begin
      decoded_word_type want;
      if (reset) begin
         decoded_q.delete();
         held_state = urldec_pkg::HELD_NONE;
         held_char = 8'h00;
         plus_space = 1'b1;
      end else begin
         if (csr_wr_en) begin
            plus_space = csr_wr_data;
         end
         if (req_valid && req_ready) begin
            decode_word(req_in_byte, req_in_last);
         end
         if (rsp_valid && rsp_ready) begin
            if (decoded_q.size() == 0) begin
               errors = errors + 1;
               $display("%0t checker: unexpected word, expected none, actual byte %02h last %0b",
                        $time, rsp_out_byte, rsp_out_last);
            end else begin
               want = decoded_q.pop_front();
               if (want.data !== rsp_out_byte) begin
                  errors = errors + 1;
                  $display("%0t checker: out_byte expected %02h actual %02h",
                           $time, want.data, rsp_out_byte);
               end
               if (want.last !== rsp_out_last) begin
                  errors = errors + 1;
                  $display("%0t checker: out_last expected %0b actual %0b",
                           $time, want.last, rsp_out_last);
               end
            end
         end
      end
      mismatch_count <= errors;
      pending_count <= decoded_q.size();
   end

endmodule

>>> dv/tb_top.sv
// Testbench top for the URL percent decoder: clock, reset, stimulus, stalls and the verdict.
`timescale 1ns / 1ps

module tb_top;

   localparam int WORD_TARGET = 450;
   localparam int PHASES      = 5;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE      = 8;

   typedef enum int {
      RX_ALWAYS,
      RX_COIN,
      RX_QUARTER,
      RX_MOSTLY,
      RX_BURSTY
   } rx_mode_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_in_byte;
   logic       req_in_last;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;
   logic       csr_wr_en;
   logic       csr_wr_data;

   int         mismatch_count;
   int         pending_count;
   int         words_sent = 0;
   int         burst_left = 1;
   int         quiet_cycles = 0;
   bit         hold_request = 1'b0;
   bit         hold_done = 1'b0;
   logic [7:0] text_q[$];

   url_percent_decoder u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .req_in_last  (req_in_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   urldec_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_in_byte    (req_in_byte),
      .req_in_last    (req_in_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_last   (rsp_out_last),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] rand_hex();
      int pick;
      pick = $urandom_range(0, 21);
      if (pick < 10) begin
         return 8'(8'h30 + pick);
      end
      if (pick < 16) begin
         return 8'(8'h61 + pick - 10);
      end
      return 8'(8'h41 + pick - 16);
   endfunction

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic send_word(input logic [7:0] b, input logic last);
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_in_last <= last;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) :
                      $urandom_range(1, 30);
      end
   endtask

   task automatic send_text();
      for (int i = 0; i < text_q.size(); i++) begin
         send_word(text_q[i], i == text_q.size() - 1);
      end
      text_q.delete();
   endtask

   task automatic send_chars(input string s);
      for (int i = 0; i < s.len(); i++) begin
         text_q.push_back(s[i]);
      end
      send_text();
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Well-formed escapes with random digits, mixed with plus signs, broken escapes and raw noise.
   task automatic build_random_string();
      int units;
      int kind;
      units = $urandom_range(1, 8);
      if ($urandom_range(0, 9) == 0) begin
         for (int k = 0; k < units; k++) begin
            text_q.push_back(rand_byte());
         end
      end else begin
         for (int k = 0; k < units; k++) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
               text_q.push_back(urldec_pkg::CHAR_PCT);
               text_q.push_back(rand_hex());
               text_q.push_back(rand_hex());
            end else if (kind < 55) begin
               text_q.push_back(urldec_pkg::CHAR_PLUS);
            end else if (kind < 62) begin
               text_q.push_back(urldec_pkg::CHAR_PCT);
               text_q.push_back(rand_byte());
            end else if (kind < 68) begin
               text_q.push_back(urldec_pkg::CHAR_PCT);
               text_q.push_back(rand_hex());
               text_q.push_back(rand_byte());
            end else if (kind < 72) begin
               text_q.push_back(urldec_pkg::CHAR_PCT);
            end else if (kind < 76) begin
               text_q.push_back(urldec_pkg::CHAR_PCT);
               text_q.push_back(rand_hex());
            end else begin
               text_q.push_back(rand_byte());
            end
         end
      end
   endtask

   initial begin
      rx_mode_type mode;
      int          mode_left;
      int          tick;
      rsp_ready = 1'b0;
      mode = RX_ALWAYS;
      mode_left = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode = rx_mode_type'($urandom_range(0, 4));
               mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            tick++;
            case (mode)
               RX_ALWAYS: rsp_ready <= 1'b1;
               RX_COIN: rsp_ready <= 1'($urandom_range(0, 1));
               RX_QUARTER: rsp_ready <= (tick % 4 == 0);
               RX_MOSTLY: rsp_ready <= ($urandom_range(0, 7) != 0);
               default: rsp_ready <= ((tick / 8) % 2 == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int phase_goal;
      req_valid = 1'b0;
      req_in_byte = 8'h00;
      req_in_last = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_csr(1'b1);

      send_chars("%41");
      send_chars("%fF+");
      send_chars("%4%");
      send_chars("%+%");
      send_chars("%%0A");
      text_q.push_back(8'h00);
      text_q.push_back(8'hFF);
      send_text();
      send_chars("%9");
      drain();
      write_csr(1'b0);
      send_chars("+%2B");
      drain();

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         if (phase == 0) begin
            write_csr(1'b1);
         end else if (phase == 1) begin
            write_csr(1'b0);
         end else begin
            write_csr(1'($urandom_range(0, 1)));
         end
         phase_goal = words_sent + WORD_TARGET / PHASES;
         while (words_sent < phase_goal) begin
            build_random_string();
            send_text();
            if (!hold_request && words_sent >= WORD_TARGET / 2) begin
               hold_request = 1'b1;
            end
         end
      end

      drain();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
